FILE: hw/rtl/block_average_tilt_angle_top_macros.svh
// Assertion macros shared by the RTL.
`ifndef BLOCK_AVERAGE_TILT_ANGLE_TOP_MACROS_SVH
`define BLOCK_AVERAGE_TILT_ANGLE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bat_pkg.sv
package bat_pkg;

	// Block and CORDIC configuration
	localparam int BLOCK_LEN    = 20;
	localparam int CORDIC_STEPS = 14;

	// Field and datapath widths
	localparam int SAMPLE_W = 14;
	localparam int SUM_W    = 22;
	localparam int CNT_W    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam int AVG_W    = 15;
	localparam int ANGLE_W  = 15;
	localparam int MAG_W    = SUM_W;
	localparam int XY_W     = 25;
	localparam int ACC_W    = 24;

	// Constant divide by reciprocal multiply
	localparam int DIV_SHIFT = 22;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam int PROD_W    = MAG_W + RECIP_W;
	localparam int REM_W     = MAG_W + 9;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / BLOCK_LEN);

	// Arctangent table and angle constants
	localparam int ATAN_N = 20;
	localparam int ITER_W = $clog2(ATAN_N);
	localparam int HALF_PI_Q20 = 1647099;
	localparam int PI_Q12      = 12868;
	localparam int PI_ACC      = PI_Q12 * 256;

	// Block queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
	} blk_sums_t;

	// atan(2^-i) in radians with 20 fraction bits, rounded to nearest
	function automatic logic signed [ACC_W-1:0] atan_q20(input logic [ITER_W-1:0] idx);
		logic signed [ACC_W-1:0] v;
		unique case (idx)
			5'd0:  v = ACC_W'(823550);
			5'd1:  v = ACC_W'(486170);
			5'd2:  v = ACC_W'(256879);
			5'd3:  v = ACC_W'(130396);
			5'd4:  v = ACC_W'(65451);
			5'd5:  v = ACC_W'(32757);
			5'd6:  v = ACC_W'(16383);
			5'd7:  v = ACC_W'(8192);
			5'd8:  v = ACC_W'(4096);
			5'd9:  v = ACC_W'(2048);
			5'd10: v = ACC_W'(1024);
			5'd11: v = ACC_W'(512);
			5'd12: v = ACC_W'(256);
			5'd13: v = ACC_W'(128);
			5'd14: v = ACC_W'(64);
			5'd15: v = ACC_W'(32);
			5'd16: v = ACC_W'(16);
			5'd17: v = ACC_W'(8);
			5'd18: v = ACC_W'(4);
			5'd19: v = ACC_W'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/bat_queue.sv
module bat_queue
	import bat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  blk_sums_t wdata,
	output logic      full,
	input  logic      pop,
	output blk_sums_t rdata,
	output logic      empty
);

	blk_sums_t          entries_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	// Flag occupancy and gate transfers
	always_comb begin
		full    = (cnt_q == QCNT_W'(QDEPTH));
		empty   = (cnt_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = entries_q[rd_q];
	end

	// Hold entries and advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				entries_q[wr_q] <= wdata;
				wr_q            <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/bat_front.sv
module bat_front
	import bat_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample_y,
	input  logic signed [SAMPLE_W-1:0] sample_z,
	output logic                       blk_push,
	output blk_sums_t                  blk_sums,
	input  logic                       blk_full
);

	logic signed [SUM_W-1:0] sum_y_q;
	logic signed [SUM_W-1:0] sum_z_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] nxt_y;
	logic signed [SUM_W-1:0] nxt_z;
	logic                    last;
	logic                    take;

	// Add the sample and close the block on its last sample
	always_comb begin
		nxt_y    = sum_y_q + SUM_W'(sample_y);
		nxt_z    = sum_z_q + SUM_W'(sample_z);
		last     = (cnt_q == CNT_W'(BLOCK_LEN - 1));
		full     = last && blk_full;
		take     = push && !full;
		blk_push = take && last;
		blk_sums = '{sum_y: nxt_y, sum_z: nxt_z};
	end

	// Hold running sums and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			if (last) begin
				sum_y_q <= '0;
				sum_z_q <= '0;
				cnt_q   <= '0;
			end else begin
				sum_y_q <= nxt_y;
				sum_z_q <= nxt_z;
				cnt_q   <= cnt_q + 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/bat_back.sv
module bat_back
	import bat_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      blk_empty,
	input  blk_sums_t                 blk_sums,
	output logic                      blk_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [ANGLE_W-1:0] tilt_angle
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_INIT,
		ST_ROT,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic                      neg_y_q;
	logic                      neg_z_q;
	logic [MAG_W-1:0]          mag_y_q;
	logic [MAG_W-1:0]          mag_z_q;
	logic [PROD_W-1:0]         prod_y_q;
	logic [PROD_W-1:0]         prod_z_q;
	logic signed [AVG_W-1:0]   avg_y_q;
	logic signed [AVG_W-1:0]   avg_z_q;
	logic signed [XY_W-1:0]    x_q;
	logic signed [XY_W-1:0]    y_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ITER_W-1:0]         iter_q;
	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] out_angle_q;

	logic signed [XY_W-1:0]    x0;
	logic signed [XY_W-1:0]    y0;
	logic signed [XY_W-1:0]    xs;
	logic signed [XY_W-1:0]    ys;
	logic signed [ACC_W-1:0]   atan_v;
	logic [ACC_W-1:0]          acc_mag;
	logic [ACC_W-1:0]          rnd;
	logic [ANGLE_W-1:0]        sat;
	logic signed [ANGLE_W-1:0] angle;
	logic                      out_free;
	logic                      load_out;

	// Magnitude of a signed block sum
	function automatic logic [MAG_W-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
		return s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
	endfunction

	// Correct the reciprocal estimate and restore the sign
	function automatic logic signed [AVG_W-1:0] div_fix(input logic [MAG_W-1:0] mag,
			input logic [PROD_W-1:0] prod, input logic neg);
		logic [MAG_W-1:0] q0;
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] q;
		q0  = prod[DIV_SHIFT +: MAG_W];
		rem = REM_W'(mag) - REM_W'(q0) * REM_W'(BLOCK_LEN);
		q   = (rem >= REM_W'(BLOCK_LEN)) ? q0 + 1'b1 : q0;
		return neg ? AVG_W'(-q) : AVG_W'(q);
	endfunction

	// Scale averages, rotate one step, and round the angle
	always_comb begin
		x0       = XY_W'(avg_y_q) <<< 8;
		y0       = XY_W'(avg_z_q) <<< 8;
		xs       = x_q >>> iter_q;
		ys       = y_q >>> iter_q;
		atan_v   = atan_q20(iter_q);
		acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		rnd      = (acc_mag + ACC_W'(128)) >> 8;
		sat      = (rnd > ACC_W'(PI_Q12)) ? ANGLE_W'(PI_Q12) : rnd[ANGLE_W-1:0];
		angle    = acc_q[ACC_W-1] ? ANGLE_W'(-sat) : ANGLE_W'(sat);
		out_free = !out_valid_q || pop;
		load_out = (state_q == ST_DONE) && out_free;
		blk_pop  = (state_q == ST_IDLE) && !blk_empty;
	end

	assign empty      = !out_valid_q;
	assign tilt_angle = out_angle_q;

	// Sequence divide, CORDIC and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_y_q     <= 1'b0;
			neg_z_q     <= 1'b0;
			mag_y_q     <= '0;
			mag_z_q     <= '0;
			prod_y_q    <= '0;
			prod_z_q    <= '0;
			avg_y_q     <= '0;
			avg_z_q     <= '0;
			x_q         <= '0;
			y_q         <= '0;
			acc_q       <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
			out_angle_q <= '0;
		end else begin
			// Load a finished angle, or drop the result once popped
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!blk_empty) begin
						neg_y_q <= blk_sums.sum_y[SUM_W-1];
						neg_z_q <= blk_sums.sum_z[SUM_W-1];
						mag_y_q <= sum_mag(blk_sums.sum_y);
						mag_z_q <= sum_mag(blk_sums.sum_z);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_y_q <= PROD_W'(mag_y_q) * PROD_W'(RECIP);
					prod_z_q <= PROD_W'(mag_z_q) * PROD_W'(RECIP);
					state_q  <= ST_FIX;
				end
				ST_FIX: begin
					avg_y_q <= div_fix(mag_y_q, prod_y_q, neg_y_q);
					avg_z_q <= div_fix(mag_z_q, prod_z_q, neg_z_q);
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					iter_q <= '0;
					if (avg_z_q == '0) begin
						// Vector on the Y axis: angle is zero or pi
						acc_q   <= (avg_y_q < 0) ? ACC_W'(PI_ACC) : '0;
						state_q <= ST_DONE;
					end else begin
						if (avg_y_q < 0) begin
							// Quarter turn into the right half plane
							if (avg_z_q > 0) begin
								x_q   <= y0;
								y_q   <= -x0;
								acc_q <= ACC_W'(HALF_PI_Q20);
							end else begin
								x_q   <= -y0;
								y_q   <= x0;
								acc_q <= -ACC_W'(HALF_PI_Q20);
							end
						end else begin
							x_q   <= x0;
							y_q   <= y0;
							acc_q <= '0;
						end
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (y_q < 0) begin
						x_q   <= x_q - ys;
						y_q   <= y_q + xs;
						acc_q <= acc_q - atan_v;
					end else begin
						x_q   <= x_q + ys;
						y_q   <= y_q - xs;
						acc_q <= acc_q + atan_v;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_angle_q <= angle;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/block_average_tilt_angle_top.sv
// Block-average tilt angle.
// Input channel: drive sample_y and sample_z with push; a sample transfers on
// a rising edge with push high and full low. Every BLOCK_LEN samples the Y and
// Z sums are divided by BLOCK_LEN (toward zero) and atan2(avg_z, avg_y) is
// produced as a signed Q3.12 angle in radians.
// Output channel: tilt_angle is valid while empty is low and transfers on a
// rising edge with pop high and empty low.
// Throughput: one sample per cycle while full is low. full rises only on the
// last sample of a block, when the two-entry block queue is full.
// The back end takes each block through its divider and iterative CORDIC
// rotator, and takes no new block from the queue until its finished angle
// moves into the output register.
// Reset (arst_n low) clears the sums, the sample count, the block queue and the output register.
// When the receiver stalls, a finished angle waits in the output register,
// the next block waits in the back end and the block queue, and sampling
// goes on until the queue is full.
`include "block_average_tilt_angle_top_macros.svh"

module block_average_tilt_angle_top
	import bat_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample_y,
	input  logic signed [SAMPLE_W-1:0] sample_z,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [ANGLE_W-1:0]  tilt_angle
);

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	blk_sums_t q_wdata;
	blk_sums_t q_rdata;

	bat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample_y (sample_y),
		.sample_z (sample_z),
		.blk_push (q_push),
		.blk_sums (q_wdata),
		.blk_full (q_full)
	);

	bat_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	bat_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_empty  (q_empty),
		.blk_sums   (q_rdata),
		.blk_pop    (q_pop),
		.empty      (empty),
		.pop        (pop),
		.tilt_angle (tilt_angle)
	);

	// Checks
	`BAT_ASSERT_NOW(a_no_queue_overflow, q_push, !q_full, "block pushed into a full queue")
	`BAT_ASSERT_NOW(a_full_needs_queue, full, q_full, "input stalled with room in the queue")
	`BAT_ASSERT_NOW(a_angle_range, !empty, (tilt_angle <= PI_Q12) && (tilt_angle >= -PI_Q12), "tilt angle out of range")
	`BAT_ASSERT_NEXT(a_pop_frees_queue, q_pop && q_full, !q_full || q_push, "queue pop lost")

endmodule
